### hw/rtl/dsvf_pkg.sv
// ----------------------------------------------------------------------------
// dsvf_pkg
// shared constants and helpers for the voice frame slow-data builder
// ----------------------------------------------------------------------------
`default_nettype none

package dsvf_pkg;

   localparam int unsigned FRAMES_PER_SUPER = 21;
   localparam int unsigned TEXT_BYTES       = 20;
   localparam int unsigned LAST_TEXT_FRAME  = 8;

   localparam int unsigned FN_W     = 5;
   localparam int unsigned TIDX_W   = 5;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned VLOW_W   = 64;
   localparam int unsigned VLAST_W  = 8;
   localparam int unsigned SLOW_W   = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [7:0] HEADER_FRAME = 8'h80;
   localparam logic [7:0] END_FLAG     = 8'h40;
   localparam logic [7:0] BLOCK_BASE   = 8'h40;

   // scrambler key, one byte per slow-data position
   localparam logic [7:0] SCRAMBLE_0 = 8'h70;
   localparam logic [7:0] SCRAMBLE_1 = 8'h4f;
   localparam logic [7:0] SCRAMBLE_2 = 8'h93;

   localparam logic [SLOW_W-1:0] SYNC_PATTERN   = 24'h552d16;
   localparam logic [SLOW_W-1:0] FILLER_PATTERN = 24'h1629f5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_HEAD = 2'd0,
      CSR_TEXT_MID  = 2'd1,
      CSR_TEXT_TAIL = 2'd2
   } csr_index_type;

   // first text byte carried by a text frame (1..8)
   function automatic logic [TIDX_W-1:0] text_base(input logic [FN_W-1:0] fn);
      logic [TIDX_W-1:0] base;
      case (fn)
         5'd1:    base = 5'd0;
         5'd2:    base = 5'd2;
         5'd3:    base = 5'd5;
         5'd4:    base = 5'd7;
         5'd5:    base = 5'd10;
         5'd6:    base = 5'd12;
         5'd7:    base = 5'd15;
         5'd8:    base = 5'd17;
         default: base = 5'd0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/dstar_voice_frame_slow_data_builder.sv
// ----------------------------------------------------------------------------
// dstar_voice_frame_slow_data_builder
// builds one outgoing packet descriptor per voice frame: header marker,
// frame number, voice pass-through and scrambled slow-data bytes
// ----------------------------------------------------------------------------
`default_nettype none

// One voice frame goes in per cycle and one packet descriptor comes out per
// frame, through the input and result registers: the frame counter, stream
// id and header flag update as the frame enters the input register, and the
// slow-data multiplexer sits between that register and the result register.
// Throughput is one transaction per clock while rsp_ready stays high; a stall
// on the result side holds both registers and drops req_ready once both are
// full. Text registers are written through the csr_ port, which is always
// ready, and are expected to change only while no frame is in flight.
module dstar_voice_frame_slow_data_builder (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dsvf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dsvf_pkg::CSR_DATA_W-1:0]  csr_wdata,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dsvf_pkg::VLOW_W-1:0]      req_voice_low,
   input  wire logic [dsvf_pkg::VLAST_W-1:0]     req_voice_last,
   input  wire logic                             req_tx_active,
   input  wire logic [dsvf_pkg::ID_W-1:0]        req_fresh_stream_id,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_is_header,
   output logic [dsvf_pkg::ID_W-1:0]             rsp_stream_id,
   output logic [7:0]                            rsp_frame_byte,
   output logic [dsvf_pkg::VLOW_W-1:0]           rsp_voice_out_low,
   output logic [dsvf_pkg::VLAST_W-1:0]          rsp_voice_out_last,
   output logic [dsvf_pkg::SLOW_W-1:0]           rsp_slow_data
);
   import dsvf_pkg::*;

   // configuration
   logic [63:0] text_head_ff;
   logic [63:0] text_mid_ff;
   logic [31:0] text_tail_ff;

   // stream state
   logic [FN_W-1:0] frame_count_ff,   frame_count_in;
   logic [ID_W-1:0] held_id_ff,       held_id_in;
   logic            hdr_pending_ff,   hdr_pending_in;
   logic [ID_W-1:0] id_used;

   // input register
   logic               s1_valid_ff;
   logic [VLOW_W-1:0]  s1_voice_low_ff;
   logic [VLAST_W-1:0] s1_voice_last_ff;
   logic [FN_W-1:0]    s1_fn_ff;
   logic               s1_hdr_ff;
   logic               s1_active_ff;
   logic [ID_W-1:0]    s1_id_ff;

   // result register
   logic               out_valid_ff;
   logic               out_hdr_ff;
   logic [ID_W-1:0]    out_id_ff;
   logic [7:0]         out_frame_ff,      out_frame_in;
   logic [VLOW_W-1:0]  out_voice_low_ff;
   logic [VLAST_W-1:0] out_voice_last_ff;
   logic [SLOW_W-1:0]  out_slow_ff,       out_slow_in;

   logic out_load;
   logic s1_load;

   logic [FN_W-1:0]   next_fn;
   logic [FN_W-1:0]   s1_next_fn;
   logic [7:0]        text_bytes [TEXT_BYTES];
   logic [TIDX_W-1:0] tidx0, tidx1, tidx2;
   logic [7:0]        block_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_head_ff <= '0;
         text_mid_ff  <= '0;
         text_tail_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEXT_HEAD: text_head_ff <= csr_wdata;
            CSR_TEXT_MID:  text_mid_ff  <= csr_wdata;
            CSR_TEXT_TAIL: text_tail_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // handshake: result register frees when taken, input register moves on
   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign s1_load   = req_valid && req_ready;

   // stream state update on acceptance
   assign next_fn = (frame_count_ff == FN_W'(FRAMES_PER_SUPER - 1)) ?
                    '0 : frame_count_ff + FN_W'(1);
   assign id_used = (held_id_ff == '0) ? req_fresh_stream_id : held_id_ff;

   always_comb begin
      if (req_tx_active) begin
         frame_count_in = next_fn;
         held_id_in     = id_used;
         hdr_pending_in = 1'b0;
      end else begin
         frame_count_in = '0;
         held_id_in     = '0;
         hdr_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         held_id_ff     <= '0;
         hdr_pending_ff <= 1'b1;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (s1_load) begin
            frame_count_ff <= frame_count_in;
            held_id_ff     <= held_id_in;
            hdr_pending_ff <= hdr_pending_in;
         end
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_voice_low_ff  <= req_voice_low;
         s1_voice_last_ff <= req_voice_last;
         s1_fn_ff         <= frame_count_ff;
         s1_hdr_ff        <= hdr_pending_ff;
         s1_active_ff     <= req_tx_active;
         s1_id_ff         <= id_used;
      end
   end

   // slow-data selection
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         text_bytes[i]     = text_head_ff[8*i +: 8];
         text_bytes[8 + i] = text_mid_ff[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         text_bytes[16 + i] = text_tail_ff[8*i +: 8];
      end
   end

   assign tidx0      = text_base(s1_fn_ff);
   assign tidx1      = tidx0 + TIDX_W'(1);
   assign tidx2      = tidx0 + TIDX_W'(2);
   assign block_code = BLOCK_BASE | {6'd0, s1_fn_ff[2:1]};
   assign s1_next_fn = (s1_fn_ff == FN_W'(FRAMES_PER_SUPER - 1)) ?
                       '0 : s1_fn_ff + FN_W'(1);

   always_comb begin
      if (s1_hdr_ff) begin
         out_slow_in = '0;
      end else if (s1_fn_ff == '0) begin
         out_slow_in = SYNC_PATTERN;
      end else if (s1_fn_ff > FN_W'(LAST_TEXT_FRAME)) begin
         out_slow_in = FILLER_PATTERN;
      end else if (s1_fn_ff[0]) begin
         // odd frame: block code leads, two text bytes follow
         out_slow_in = {block_code ^ SCRAMBLE_0,
                        text_bytes[tidx0] ^ SCRAMBLE_1,
                        text_bytes[tidx1] ^ SCRAMBLE_2};
      end else begin
         out_slow_in = {text_bytes[tidx0] ^ SCRAMBLE_0,
                        text_bytes[tidx1] ^ SCRAMBLE_1,
                        text_bytes[tidx2] ^ SCRAMBLE_2};
      end

      if (!s1_active_ff) begin
         out_frame_in = END_FLAG | {3'd0, s1_next_fn};
      end else if (s1_hdr_ff) begin
         out_frame_in = HEADER_FRAME;
      end else begin
         out_frame_in = {3'd0, s1_fn_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hdr_ff        <= s1_hdr_ff;
         out_id_ff         <= s1_id_ff;
         out_frame_ff      <= out_frame_in;
         out_voice_low_ff  <= s1_hdr_ff ? '0 : s1_voice_low_ff;
         out_voice_last_ff <= s1_hdr_ff ? '0 : s1_voice_last_ff;
         out_slow_ff       <= out_slow_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_is_header      = out_hdr_ff;
   assign rsp_stream_id      = out_id_ff;
   assign rsp_frame_byte     = out_frame_ff;
   assign rsp_voice_out_low  = out_voice_low_ff;
   assign rsp_voice_out_last = out_voice_last_ff;
   assign rsp_slow_data      = out_slow_ff;

endmodule

`default_nettype wire
